[rtl/core/ptzr_pkg.sv]
// Shared types, constants and the command decoder for the PTZ control frame receiver.
// No dependencies; imported by every module of the block.
package ptzr_pkg;

  // Framing constants
  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] PRESET_MAX = 8'h20;
  localparam logic [2:0] PHASE_HUNT = 3'd0;
  localparam logic [2:0] PHASE_CSUM = 3'd6;
  localparam int unsigned BODY_LEN  = 5;

  // Frame status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_OTHER_AD = 2'd2;

  // Command classes
  localparam logic [3:0] CL_GOTO_PRESET  = 4'd0;
  localparam logic [3:0] CL_STOP         = 4'd1;
  localparam logic [3:0] CL_RIGHT        = 4'd2;
  localparam logic [3:0] CL_LEFT         = 4'd3;
  localparam logic [3:0] CL_DOWN         = 4'd4;
  localparam logic [3:0] CL_UP           = 4'd5;
  localparam logic [3:0] CL_ZOOM_IN      = 4'd6;
  localparam logic [3:0] CL_ZOOM_OUT     = 4'd7;
  localparam logic [3:0] CL_FOCUS_NEAR   = 4'd8;
  localparam logic [3:0] CL_FOCUS_FAR    = 4'd9;
  localparam logic [3:0] CL_IRIS_CLOSE   = 4'd10;
  localparam logic [3:0] CL_IRIS_OPEN    = 4'd11;
  localparam logic [3:0] CL_SET_PRESET   = 4'd12;
  localparam logic [3:0] CL_CLEAR_PRESET = 4'd13;
  localparam logic [3:0] CL_OTHER        = 4'd14;

  // Command byte codes
  localparam logic [7:0] CMD_GOTO    = 8'h07;
  localparam logic [7:0] CMD_RIGHT   = 8'h02;
  localparam logic [7:0] CMD_LEFT    = 8'h04;
  localparam logic [7:0] CMD_DOWN    = 8'h08;
  localparam logic [7:0] CMD_UP      = 8'h10;
  localparam logic [7:0] CMD_ZIN     = 8'h20;
  localparam logic [7:0] CMD_ZOUT    = 8'h40;
  localparam logic [7:0] CMD_FNEAR   = 8'h80;
  localparam logic [7:0] CMD1_FFAR   = 8'h10;
  localparam logic [7:0] CMD1_ICLOSE = 8'h02;
  localparam logic [7:0] CMD1_IOPEN  = 8'h04;
  localparam logic [7:0] CMD_SETP    = 8'h03;
  localparam logic [7:0] CMD_CLRP    = 8'h05;

  // Frame as seen by the result stage when the checksum byte is processed
  typedef struct packed {
    logic       done;
    logic       sum_ok;
    logic [7:0] addr;
    logic [7:0] cmd1;
    logic [7:0] cmd2;
    logic [7:0] data1;
    logic [7:0] data2;
  } frame_t;

  // Command decode, tests taken in priority order
  function automatic logic [3:0] classify(input logic [7:0] c1, input logic [7:0] c2,
                                          input logic [7:0] d1, input logic [7:0] d2);
    logic [3:0] cls;
    cls = CL_OTHER;
    if (c1 == 8'h00 && c2 == CMD_GOTO && d1 == 8'h00 && d2 <= PRESET_MAX) begin
      cls = CL_GOTO_PRESET;
    end else if (c1 == 8'h00 && c2 == 8'h00 && d1 == 8'h00 && d2 == 8'h00) begin
      cls = CL_STOP;
    end else if (c1 == 8'h00 && c2 == CMD_RIGHT) begin
      cls = CL_RIGHT;
    end else if (c1 == 8'h00 && c2 == CMD_LEFT) begin
      cls = CL_LEFT;
    end else if (c1 == 8'h00 && c2 == CMD_DOWN) begin
      cls = CL_DOWN;
    end else if (c1 == 8'h00 && c2 == CMD_UP) begin
      cls = CL_UP;
    end else if (c1 == 8'h00 && c2 == CMD_ZIN) begin
      cls = CL_ZOOM_IN;
    end else if (c1 == 8'h00 && c2 == CMD_ZOUT) begin
      cls = CL_ZOOM_OUT;
    end else if (c1 == 8'h00 && c2 == CMD_FNEAR) begin
      cls = CL_FOCUS_NEAR;
    end else if (c2 == 8'h00 && c1 == CMD1_FFAR) begin
      cls = CL_FOCUS_FAR;
    end else if (c2 == 8'h00 && c1 == CMD1_ICLOSE) begin
      cls = CL_IRIS_CLOSE;
    end else if (c2 == 8'h00 && c1 == CMD1_IOPEN) begin
      cls = CL_IRIS_OPEN;
    end else if (c1 == 8'h00 && c2 == CMD_SETP) begin
      cls = CL_SET_PRESET;
    end else if (c1 == 8'h00 && c2 == CMD_CLRP) begin
      cls = CL_CLEAR_PRESET;
    end
    return cls;
  endfunction

endpackage

[rtl/core/ptzr_framer.sv]
// Frame tracker: sync hunt, phase counter, body byte store and running checksum.
// Depends on ptzr_pkg.
module ptzr_framer
  import ptzr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_fire,
  input  logic [7:0]   byte_in,
  output frame_t       frame
);

  logic [2:0] phase;
  logic [7:0] running_sum;
  logic [7:0] body [BODY_LEN];
  logic [2:0] body_idx;
  logic       hunting;

  assign hunting  = (phase == PHASE_HUNT) || (phase > PHASE_CSUM);
  assign body_idx = 3'(phase - 3'd1);

  // Phase and checksum; phase seven is treated as hunting
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PHASE_HUNT;
      running_sum <= 8'h00;
    end else if (byte_fire) begin
      if (hunting) begin
        phase       <= (byte_in == SYNC_BYTE) ? 3'd1 : PHASE_HUNT;
        running_sum <= 8'h00;
      end else if (phase < PHASE_CSUM) begin
        phase       <= 3'(phase + 3'd1);
        running_sum <= 8'(running_sum + byte_in);
      end else begin
        phase       <= PHASE_HUNT;
        running_sum <= 8'h00;
      end
    end
  end

  // Body bytes: address, cmd1, cmd2, data1, data2
  always_ff @(posedge clk) begin
    if (byte_fire && !hunting && phase < PHASE_CSUM) begin
      body[body_idx] <= byte_in;
    end
  end

  // Frame completes when the checksum byte is processed
  always_comb begin
    frame.done   = byte_fire && (phase == PHASE_CSUM);
    frame.sum_ok = (running_sum == byte_in);
    frame.addr   = body[0];
    frame.cmd1   = body[1];
    frame.cmd2   = body[2];
    frame.data1  = body[3];
    frame.data2  = body[4];
  end

endmodule

[rtl/core/ptzr_result.sv]
// Result stage: status and command decode of a completed frame into the output register.
// Depends on ptzr_pkg (frame_t, status codes, classify).
module ptzr_result
  import ptzr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  frame_t       frame,
  input  logic [7:0]   dev_addr,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [1:0]   frame_status,
  output logic [3:0]   command_class,
  output logic [7:0]   preset_number,
  output logic         pause_request,
  output logic [15:0]  command_bytes
);

  logic [1:0] status_next;
  logic [3:0] class_next;
  logic       pause_next;

  // Checksum is tested before the address
  always_comb begin
    if (!frame.sum_ok) begin
      status_next = ST_BAD_SUM;
    end else if (frame.addr != dev_addr) begin
      status_next = ST_OTHER_AD;
    end else begin
      status_next = ST_ACCEPTED;
    end
    class_next = classify(frame.cmd1, frame.cmd2, frame.data1, frame.data2);
    pause_next = (status_next == ST_ACCEPTED) &&
                 (class_next >= CL_RIGHT) && (class_next <= CL_IRIS_OPEN);
  end

  // Output valid: set on a completed frame, held while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (frame.done) begin
      frame_status  <= status_next;
      command_class <= class_next;
      preset_number <= frame.data2;
      pause_request <= pause_next;
      command_bytes <= {frame.cmd1, frame.cmd2};
    end
  end

endmodule

[rtl/core/ptz_control_frame_receiver.sv]
// PTZ control frame receiver: one byte per cycle, one result per completed seven-byte frame.
// The checksum byte passes the input register and then the result register;
// it waits in the input register behind a stalled result.
// Throughput: one byte per cycle; the input register stalls only while a result is stalled.
// Reset (rst, synchronous, active high): hunting for sync, sum cleared, address set to 1.
// Depends on ptzr_pkg, ptzr_framer and ptzr_result.
module ptz_control_frame_receiver
  import ptzr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [7:0]   cfg_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   rx_byte,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   frame_status,
  output logic [3:0]   command_class,
  output logic [7:0]   preset_number,
  output logic         pause_request,
  output logic [15:0]  command_bytes
);

  logic       in_hold_valid;
  logic [7:0] in_hold_byte;
  logic [7:0] device_address;
  logic       advance;
  logic       byte_fire;
  frame_t     frame;

  // Device address register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'h01;
    end else if (cfg_write) begin
      device_address <= cfg_data;
    end
  end

  // Pipeline moves unless a result is held by the consumer
  assign advance   = !(out_valid && out_stall);
  assign byte_fire = in_hold_valid && advance;
  assign in_stall  = in_hold_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_hold_valid <= 1'b0;
    end else if (!in_stall) begin
      in_hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_hold_byte <= rx_byte;
    end
  end

  ptzr_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .byte_fire (byte_fire),
    .byte_in   (in_hold_byte),
    .frame     (frame)
  );

  ptzr_result u_result (
    .clk           (clk),
    .rst           (rst),
    .frame         (frame),
    .dev_addr      (device_address),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .frame_status  (frame_status),
    .command_class (command_class),
    .preset_number (preset_number),
    .pause_request (pause_request),
    .command_bytes (command_bytes)
  );

endmodule

[rtl/core/ptzr_checker.sv]
// Port-level checks for the PTZ control frame receiver, bound to the top level.
// Depends on ptzr_pkg for status and class codes.
module ptzr_checker
  import ptzr_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input logic [1:0]   frame_status,
  input logic [3:0]   command_class,
  input logic         pause_request
);

  // Nothing is offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");

  // Pause only for accepted pan, tilt, zoom, focus or iris frames
  a_pause: assert property (@(posedge clk) disable iff (rst)
    out_valid && pause_request |->
      frame_status == ST_ACCEPTED && command_class >= CL_RIGHT &&
      command_class <= CL_IRIS_OPEN)
    else $error("pause on a frame that must not pause");

  // Status and class stay within their codes
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_status <= ST_OTHER_AD && command_class <= CL_OTHER)
    else $error("status or class out of range");

endmodule

bind ptz_control_frame_receiver ptzr_checker u_ptzr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .frame_status  (frame_status),
  .command_class (command_class),
  .pause_request (pause_request)
);

[sim/ptz_control_frame_receiver_tb.sv]
// Self-checking testbench for ptz_control_frame_receiver: byte streams of framed commands,
// noise and broken frames under random idling, checked against a frame decoder of its own.
// Depends on ptzr_pkg and the RTL of the block.
module ptz_control_frame_receiver_tb;
  import ptzr_pkg::*;

  // One decoded frame as it leaves the block
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  cls;
    logic [7:0]  preset;
    logic        pause;
    logic [15:0] cmd;
  } frame_result_t;

  // Frame decoder and store of pending results
  class frame_scoreboard;
    logic [7:0]    camera_addr;
    logic [2:0]    phase;
    logic [7:0]    body [5];
    logic [7:0]    sum;
    frame_result_t expected_q [$];
    int            errors;
    int            checked;
    int            status_count [3];
    logic [15:0]   classes_seen;

    function new();
      camera_addr  = 8'd1;
      phase        = PHASE_HUNT;
      sum          = 8'd0;
      errors       = 0;
      checked      = 0;
      status_count = '{0, 0, 0};
      classes_seen = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Command class from the four command and data bytes
    function logic [3:0] decode_command(logic [7:0] c1, logic [7:0] c2,
                                        logic [7:0] d1, logic [7:0] d2);
      if (c1 == 8'h00) begin
        if (c2 == CMD_GOTO && d1 == 8'h00 && d2 <= PRESET_MAX) return CL_GOTO_PRESET;
        if (c2 == 8'h00 && d1 == 8'h00 && d2 == 8'h00) return CL_STOP;
        case (c2)
          CMD_RIGHT: return CL_RIGHT;
          CMD_LEFT:  return CL_LEFT;
          CMD_DOWN:  return CL_DOWN;
          CMD_UP:    return CL_UP;
          CMD_ZIN:   return CL_ZOOM_IN;
          CMD_ZOUT:  return CL_ZOOM_OUT;
          CMD_FNEAR: return CL_FOCUS_NEAR;
          CMD_SETP:  return CL_SET_PRESET;
          CMD_CLRP:  return CL_CLEAR_PRESET;
          default:   return CL_OTHER;
        endcase
      end else if (c2 == 8'h00) begin
        case (c1)
          CMD1_FFAR:   return CL_FOCUS_FAR;
          CMD1_ICLOSE: return CL_IRIS_CLOSE;
          CMD1_IOPEN:  return CL_IRIS_OPEN;
          default:     return CL_OTHER;
        endcase
      end
      return CL_OTHER;
    endfunction

    // Advance the framing state by one accepted byte
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      if (phase == PHASE_HUNT || phase > PHASE_CSUM) begin
        phase = (b == SYNC_BYTE) ? 3'd1 : PHASE_HUNT;
        sum   = 8'd0;
      end else if (phase < PHASE_CSUM) begin
        body[3'(phase - 3'd1)] = b;
        sum   = sum + b;
        phase = phase + 3'd1;
      end else begin
        // checksum byte: checksum tested before address
        if (sum != b) r.status = ST_BAD_SUM;
        else if (body[0] != camera_addr) r.status = ST_OTHER_AD;
        else r.status = ST_ACCEPTED;
        r.cls    = decode_command(body[1], body[2], body[3], body[4]);
        r.preset = body[4];
        r.pause  = (r.status == ST_ACCEPTED && r.cls >= CL_RIGHT && r.cls <= CL_IRIS_OPEN);
        r.cmd    = {body[1], body[2]};
        expected_q.push_back(r);
        phase = PHASE_HUNT;
        sum   = 8'd0;
      end
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d class %0d preset %02h pause %0b cmd %04h",
                 $time, got.status, got.cls, got.preset, got.pause, got.cmd);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status || got.cls !== want.cls || got.preset !== want.preset ||
          got.pause !== want.pause || got.cmd !== want.cmd) begin
        $display("%0t: mismatch: expected status %0d class %0d preset %02h pause %0b cmd %04h",
                 $time, want.status, want.cls, want.preset, want.pause, want.cmd);
        $display("%0t:           got status %0d class %0d preset %02h pause %0b cmd %04h",
                 $time, got.status, got.cls, got.preset, got.pause, got.cmd);
        errors++;
      end
      if (want.status <= ST_OTHER_AD) status_count[want.status]++;
      classes_seen[want.cls] = 1'b1;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  frame_status;
  logic [3:0]  command_class;
  logic [7:0]  preset_number;
  logic        pause_request;
  logic [15:0] command_bytes;

  frame_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int bytes_sent = 0;

  always #5 clk = ~clk;

  ptz_control_frame_receiver i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_status  (frame_status),
    .command_class (command_class),
    .preset_number (preset_number),
    .pause_request (pause_request),
    .command_bytes (command_bytes)
  );

  // Result side: check each transfer, then pick the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check(frame_result_t'{frame_status, command_class, preset_number,
                                 pause_request, command_bytes});
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // One byte transfer, after a random idle gap
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Sync, body and checksum; a corrupt checksum is always wrong
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] c1, input logic [7:0] c2,
                            input logic [7:0] d1, input logic [7:0] d2, input bit corrupt);
    logic [7:0] csum;
    csum = addr + c1 + c2 + d1 + d2;
    if (corrupt) csum = csum ^ 8'($urandom_range(255, 1));
    send_byte(SYNC_BYTE);
    send_byte(addr);
    send_byte(c1);
    send_byte(c2);
    send_byte(d1);
    send_byte(d2);
    send_byte(csum);
  endtask

  // Command and data bytes for a randomly chosen command class
  task automatic pick_command(output logic [7:0] c1, output logic [7:0] c2,
                              output logic [7:0] d1, output logic [7:0] d2);
    logic [3:0] cls;
    cls = 4'($urandom_range(CL_OTHER));
    c1  = 8'h00;
    c2  = 8'h00;
    d1  = 8'($urandom);
    d2  = 8'($urandom);
    case (cls)
      CL_GOTO_PRESET: begin
        c2 = CMD_GOTO;
        d1 = 8'h00;
        d2 = 8'($urandom_range(PRESET_MAX + 1));
      end
      CL_STOP: begin
        d1 = 8'h00;
        d2 = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
      end
      CL_RIGHT:        c2 = CMD_RIGHT;
      CL_LEFT:         c2 = CMD_LEFT;
      CL_DOWN:         c2 = CMD_DOWN;
      CL_UP:           c2 = CMD_UP;
      CL_ZOOM_IN:      c2 = CMD_ZIN;
      CL_ZOOM_OUT:     c2 = CMD_ZOUT;
      CL_FOCUS_NEAR:   c2 = CMD_FNEAR;
      CL_FOCUS_FAR:    c1 = CMD1_FFAR;
      CL_IRIS_CLOSE:   c1 = CMD1_ICLOSE;
      CL_IRIS_OPEN:    c1 = CMD1_IOPEN;
      CL_SET_PRESET:   c2 = CMD_SETP;
      CL_CLEAR_PRESET: c2 = CMD_CLRP;
      default: begin
        c1 = 8'($urandom);
        c2 = 8'($urandom);
      end
    endcase
  endtask

  // Address write once the block has drained
  task automatic set_camera_address(input logic [7:0] a);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.camera_addr = a;
  endtask

  // Mostly well-formed frames, with noise, cut-short frames and sync runs
  task automatic run_phase(input int idle_pct, input int stall_pct, input logic [7:0] addr,
                           input int n_bytes);
    int target;
    int pick;
    logic [7:0] a, c1, c2, d1, d2;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    set_camera_address(addr);
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        pick_command(c1, c2, d1, d2);
        a = ($urandom_range(99) < 85) ? sb.camera_addr : 8'($urandom);
        send_frame(a, c1, c2, d1, d2, $urandom_range(99) < 15);
      end else if (pick < 85) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else if (pick < 93) begin
        send_byte(SYNC_BYTE);
        repeat ($urandom_range(5)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(SYNC_BYTE);
      end
    end
  endtask

  // Run limit
  initial begin
    #2000000;
    $display("ptz_control_frame_receiver test failed");
    $finish;
  end

  // Main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: noise, goto preset at its limit, all-ones frame with bad sum,
    // good frame for another camera
    send_byte(8'h00);
    send_frame(8'd1, 8'h00, CMD_GOTO, 8'h00, PRESET_MAX, 1'b0);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_frame(8'h00, 8'h00, CMD_RIGHT, 8'h00, 8'h00, 1'b0);

    // random phases across idling patterns and camera addresses
    run_phase(0, 0, 8'h00, 490);
    run_phase(53, 0, 8'hFF, 490);
    run_phase(0, 53, 8'($urandom), 490);
    run_phase(30, 30, 8'd1, 490);

    in_valid <= 1'b0;
    for (int k = 0; k < 5000 && sb.pending() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors += sb.pending();
    end

    $display("Covered %0d bytes, %0d frames: %0d accepted, %0d bad checksum, %0d other address",
             bytes_sent, sb.checked, sb.status_count[0], sb.status_count[1],
             sb.status_count[2]);
    $display("%0d of 15 command classes decoded, four addresses, four idling patterns",
             $countones(sb.classes_seen));
    if (sb.errors == 0) begin
      $display("ptz_control_frame_receiver test passed");
    end else begin
      $display("ptz_control_frame_receiver test failed");
    end
    $finish;
  end

endmodule
